### rtl/imsu_pkg.sv
// shared types and constants for the ising metropolis site update core
`default_nettype none

package imsu_pkg;

    // lattice geometry and random fraction width
    localparam int SIDE      = 64;
    localparam int COORD_W   = $clog2(SIDE);
    localparam int RAND_BITS = 16;

    // field widths
    localparam int DATA_W    = 16;
    localparam int SITE_W    = 6;
    localparam int ENERGY_W  = 15;
    localparam int MAG_W     = 14;
    localparam int CFG_IDX_W = 8;

    // low bits of the random fraction that take part in the compare
    localparam logic [DATA_W-1:0] RAND_MASK = DATA_W'((64'd1 << RAND_BITS) - 64'd1);

    // running totals after reset or restart: every spin up
    localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SIDE * SIDE);
    localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(SIDE * SIDE);

    // threshold register reset values
    localparam logic [DATA_W-1:0] LEVEL4_RESET = 16'd8192;
    localparam logic [DATA_W-1:0] LEVEL8_RESET = 16'd1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL4 = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL8 = 8'd1;

    // input op codes
    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_MID,
        ST_RD_DN,
        ST_FIN,
        ST_RESTART
    } t_state;

    // which lattice row the read port fetches
    typedef enum logic [1:0] {
        RD_UP,
        RD_MID,
        RD_DN
    } t_rd_sel;

    // controller to datapath commands
    typedef struct packed {
        logic    take;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_up;
        logic    cap_mid;
        logic    commit;
        logic    restart;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/ising_metropolis_site_update_core.sv
// top level of the ising metropolis site update core
// Metropolis update of a periodic SIDE x SIDE lattice of one-bit spins, one site per
// input transfer in raster order.
// Input channel: i_in_valid / o_in_ready with i_op and i_random_fraction. op update visits
// the next site; op restart sets every spin up and resets position and totals.
// Output channel: o_out_valid / i_out_ready, one result per input transfer, carrying the
// site, acceptance, new spin, running energy, magnetization and the end of sweep flag.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index selects
// accept_level_4 (0) or accept_level_8 (1); other indexes are dropped.
// Timing: an update passes the idle, middle row read, lower row read and finish states,
// set by the three row reads through the single read port of the lattice memory plus
// the update in the finish state, which registers the result. A restart passes the restart
// state. Input is taken only in the idle state, so each site finishes before the next is taken.
// Stall: the result sits in an output register; a finished update waits for that
// register to free before it writes the lattice, holding the input channel not ready.
// Reset: synchronous, active low; every spin up, position zero, thresholds to defaults.
// The lattice needs no clearing pass: per-row valid bits make unwritten rows read as up.
`default_nettype none

module ising_metropolis_site_update_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_op,
    input  wire logic [imsu_pkg::DATA_W-1:0]         i_random_fraction,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [imsu_pkg::SITE_W-1:0]         o_site_row,
    output logic      [imsu_pkg::SITE_W-1:0]         o_site_col,
    output logic                                     o_accepted,
    output logic                                     o_new_spin,
    output logic signed [imsu_pkg::ENERGY_W-1:0]     o_energy,
    output logic signed [imsu_pkg::MAG_W-1:0]        o_magnetization,
    output logic                                     o_sweep_done,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [imsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [imsu_pkg::DATA_W-1:0]         i_cfg_data
);

    imsu_pkg::t_cmd                cmd;
    logic                          out_free;
    logic [imsu_pkg::ENERGY_W-1:0] energy;
    logic [imsu_pkg::MAG_W-1:0]    mag;

    assign o_cfg_ready     = 1'b1;
    assign o_energy        = energy;
    assign o_magnetization = mag;

    // sequencer
    imsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_out_free (out_free),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // lattice, totals and result register
    imsu_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_random_fraction (i_random_fraction),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_out_ready       (i_out_ready),
        .o_out_free        (out_free),
        .o_out_valid       (o_out_valid),
        .o_site_row        (o_site_row),
        .o_site_col        (o_site_col),
        .o_accepted        (o_accepted),
        .o_new_spin        (o_new_spin),
        .o_energy          (energy),
        .o_magnetization   (mag),
        .o_sweep_done      (o_sweep_done)
    );

endmodule

`default_nettype wire

### rtl/imsu_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module imsu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/imsu_ctrl.sv
// controller state machine sequencing row reads, update and restart
`default_nettype none

module imsu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_op,
    input  wire logic          i_out_free,
    output logic               o_in_ready,
    output imsu_pkg::t_cmd     o_cmd
);

    imsu_pkg::t_state r_state;
    imsu_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imsu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imsu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == imsu_pkg::OP_RESTART) ? imsu_pkg::ST_RESTART
                                                             : imsu_pkg::ST_RD_MID;
                end
            end
            imsu_pkg::ST_RD_MID: n_state = imsu_pkg::ST_RD_DN;
            imsu_pkg::ST_RD_DN:  n_state = imsu_pkg::ST_FIN;
            imsu_pkg::ST_FIN, imsu_pkg::ST_RESTART: begin
                if (i_out_free) begin
                    n_state = imsu_pkg::ST_IDLE;
                end
            end
            default: n_state = imsu_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.rd_sel  = imsu_pkg::RD_UP;
        unique case (r_state)
            imsu_pkg::ST_IDLE: begin
                // the upper row read starts while waiting for a transfer
                o_in_ready   = 1'b1;
                o_cmd.take   = i_in_valid;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = imsu_pkg::RD_UP;
            end
            imsu_pkg::ST_RD_MID: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = imsu_pkg::RD_MID;
                o_cmd.cap_up = 1'b1;
            end
            imsu_pkg::ST_RD_DN: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = imsu_pkg::RD_DN;
                o_cmd.cap_mid = 1'b1;
            end
            imsu_pkg::ST_FIN: begin
                o_cmd.commit = i_out_free;
            end
            imsu_pkg::ST_RESTART: begin
                o_cmd.restart = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/imsu_dp.sv
// datapath: lattice memory, threshold registers, energy and spin totals, result register
`default_nettype none

module imsu_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire imsu_pkg::t_cmd                      i_cmd,
    input  wire logic [imsu_pkg::DATA_W-1:0]         i_random_fraction,
    input  wire logic                                i_cfg_valid,
    input  wire logic [imsu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [imsu_pkg::DATA_W-1:0]         i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_free,
    output logic                                     o_out_valid,
    output logic      [imsu_pkg::SITE_W-1:0]         o_site_row,
    output logic      [imsu_pkg::SITE_W-1:0]         o_site_col,
    output logic                                     o_accepted,
    output logic                                     o_new_spin,
    output logic      [imsu_pkg::ENERGY_W-1:0]       o_energy,
    output logic      [imsu_pkg::MAG_W-1:0]          o_magnetization,
    output logic                                     o_sweep_done
);

    localparam logic [imsu_pkg::COORD_W-1:0] LAST = imsu_pkg::COORD_W'(imsu_pkg::SIDE - 1);

    // threshold registers
    logic [imsu_pkg::DATA_W-1:0] r_level4;
    logic [imsu_pkg::DATA_W-1:0] r_level8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level4 <= imsu_pkg::LEVEL4_RESET;
            r_level8 <= imsu_pkg::LEVEL8_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imsu_pkg::CFG_LEVEL4: r_level4 <= i_cfg_data;
                imsu_pkg::CFG_LEVEL8: r_level8 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // position, totals and row valid bits
    logic [imsu_pkg::COORD_W-1:0]  r_row, n_row;
    logic [imsu_pkg::COORD_W-1:0]  r_col, n_col;
    logic [imsu_pkg::ENERGY_W-1:0] r_energy, n_energy;
    logic [imsu_pkg::MAG_W-1:0]    r_mag, n_mag;
    logic [imsu_pkg::SIDE-1:0]     r_row_ok;
    logic [imsu_pkg::DATA_W-1:0]   r_rnd;

    // lattice memory read side
    logic [imsu_pkg::COORD_W-1:0] rd_addr;
    logic [imsu_pkg::SIDE-1:0]    rd_data;
    logic [imsu_pkg::SIDE-1:0]    row_eff;
    logic                         r_rd_ok;
    logic [imsu_pkg::SIDE-1:0]    r_up_row;
    logic [imsu_pkg::SIDE-1:0]    r_mid_row;

    always_comb begin
        case (i_cmd.rd_sel)
            imsu_pkg::RD_UP:  rd_addr = (r_row == '0) ? LAST : r_row - 1'b1;
            imsu_pkg::RD_DN:  rd_addr = (r_row == LAST) ? '0 : r_row + 1'b1;
            default:          rd_addr = r_row;
        endcase
    end

    // a row never written since reset or restart reads as all spins up
    assign row_eff = r_rd_ok ? rd_data : '1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_ok <= r_row_ok[rd_addr];
        end
        if (i_cmd.cap_up) begin
            r_up_row <= row_eff;
        end
        if (i_cmd.cap_mid) begin
            r_mid_row <= row_eff;
        end
        if (i_cmd.take) begin
            r_rnd <= i_random_fraction & imsu_pkg::RAND_MASK;
        end
    end

    // neighbor spins, lower row comes straight from the read port
    logic [imsu_pkg::COORD_W-1:0] col_left, col_right;
    logic                         spin, nb_up, nb_dn, nb_left, nb_right;
    logic [2:0]                   up_count, aligned;
    logic                         acc;
    logic [imsu_pkg::ENERGY_W-1:0] de;
    logic [imsu_pkg::SIDE-1:0]    new_row;
    logic                         sweep_end;

    always_comb begin
        col_left  = (r_col == '0) ? LAST : r_col - 1'b1;
        col_right = (r_col == LAST) ? '0 : r_col + 1'b1;
        spin      = r_mid_row[r_col];
        nb_up     = r_up_row[r_col];
        nb_dn     = row_eff[r_col];
        nb_left   = r_mid_row[col_left];
        nb_right  = r_mid_row[col_right];
        up_count  = 3'(nb_up) + 3'(nb_dn) + 3'(nb_left) + 3'(nb_right);
        // neighbors aligned with the site: dE = 4 * aligned - 8
        aligned   = spin ? up_count : 3'd4 - up_count;
        case (aligned)
            3'd3:    acc = r_rnd < r_level4;
            3'd4:    acc = r_rnd < r_level8;
            default: acc = 1'b1;
        endcase
        de        = imsu_pkg::ENERGY_W'({aligned, 2'b00}) - imsu_pkg::ENERGY_W'(8);
        new_row   = r_mid_row;
        new_row[r_col] = spin ^ acc;
        sweep_end = (r_row == LAST) && (r_col == LAST);
    end

    // next position and totals
    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_energy = r_energy;
        n_mag    = r_mag;
        if (i_cmd.restart) begin
            n_row    = '0;
            n_col    = '0;
            n_energy = imsu_pkg::ENERGY_RESET;
            n_mag    = imsu_pkg::MAG_RESET;
        end else if (i_cmd.commit) begin
            if (acc) begin
                n_energy = r_energy + de;
                n_mag    = spin ? r_mag - imsu_pkg::MAG_W'(2) : r_mag + imsu_pkg::MAG_W'(2);
            end
            if (r_col == LAST) begin
                n_col = '0;
                n_row = (r_row == LAST) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_energy <= imsu_pkg::ENERGY_RESET;
            r_mag    <= imsu_pkg::MAG_RESET;
            r_row_ok <= '0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_energy <= n_energy;
            r_mag    <= n_mag;
            if (i_cmd.restart) begin
                r_row_ok <= '0;
            end else if (i_cmd.commit) begin
                r_row_ok[r_row] <= 1'b1;
            end
        end
    end

    // lattice rows
    imsu_ram #(
        .WIDTH (imsu_pkg::SIDE),
        .DEPTH (imsu_pkg::SIDE)
    ) u_lattice (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (r_row),
        .i_wr_data (new_row),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register
    logic                          r_out_valid;
    logic [imsu_pkg::SITE_W-1:0]   r_site_row, r_site_col;
    logic                          r_accepted, r_new_spin, r_sweep_done;
    logic [imsu_pkg::ENERGY_W-1:0] r_out_energy;
    logic [imsu_pkg::MAG_W-1:0]    r_out_mag;

    assign o_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.restart) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            r_site_row   <= '0;
            r_site_col   <= '0;
            r_accepted   <= 1'b0;
            r_new_spin   <= 1'b1;
            r_out_energy <= imsu_pkg::ENERGY_RESET;
            r_out_mag    <= imsu_pkg::MAG_RESET;
            r_sweep_done <= 1'b0;
        end else if (i_cmd.commit) begin
            r_site_row   <= imsu_pkg::SITE_W'(r_row);
            r_site_col   <= imsu_pkg::SITE_W'(r_col);
            r_accepted   <= acc;
            r_new_spin   <= spin ^ acc;
            r_out_energy <= n_energy;
            r_out_mag    <= n_mag;
            r_sweep_done <= sweep_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_site_row      = r_site_row;
    assign o_site_col      = r_site_col;
    assign o_accepted      = r_accepted;
    assign o_new_spin      = r_new_spin;
    assign o_energy        = r_out_energy;
    assign o_magnetization = r_out_mag;
    assign o_sweep_done    = r_sweep_done;

endmodule

`default_nettype wire
